// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that holds at every clock edge outside reset.
`define ASV_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check on the edge after a trigger.
`define ASV_ASSERT_NEXT(label, trig, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) trig |=> prop) else $error(msg);

`endif

// ===== rtl/core/asv_pkg.sv =====
`default_nettype none
package asv_pkg;

   localparam int MAX_DEPTH = 64;
   localparam int DEPTH_W   = 7;

   localparam logic [3:0] TK_MAGIC     = 4'd0;
   localparam logic [3:0] TK_REG       = 4'd1;
   localparam logic [3:0] TK_SYM       = 4'd2;
   localparam logic [3:0] TK_DIR       = 4'd3;
   localparam logic [3:0] TK_EXEC      = 4'd4;
   localparam logic [3:0] TK_CONT      = 4'd5;
   localparam logic [3:0] TK_CONT_ONLY = 4'd6;
   localparam logic [3:0] TK_TARG      = 4'd7;
   localparam logic [3:0] TK_NAME      = 4'd8;
   localparam logic [3:0] TK_ENTRY     = 4'd9;
   localparam logic [3:0] TK_END       = 4'd10;
   localparam int         TK_COUNT     = 11;

   localparam logic [1:0] LK_CONT = 2'd0;
   localparam logic [1:0] LK_TARG = 2'd1;
   localparam logic [1:0] LK_NAME = 2'd2;

   localparam logic [2:0] CLS_TOKEN   = 3'd0;
   localparam logic [2:0] CLS_LENGTH  = 3'd1;
   localparam logic [2:0] CLS_CONTENT = 3'd2;
   localparam logic [2:0] CLS_NAME    = 3'd3;
   localparam logic [2:0] CLS_TARGET  = 3'd4;
   localparam logic [2:0] CLS_IGNORED = 3'd5;

   localparam logic [1:0] ST_RUNNING = 2'd0;
   localparam logic [1:0] ST_DONE    = 2'd1;
   localparam logic [1:0] ST_ERROR   = 2'd2;

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_REG  = 2'd1;
   localparam logic [1:0] KIND_SYM  = 2'd2;
   localparam logic [1:0] KIND_DIR  = 2'd3;

   localparam logic CSR_MAX_TARGET = 1'b0;
   localparam logic CSR_MAX_NAME   = 1'b1;

   typedef enum logic [6:0] {
      PH_TOKEN   = 7'b0000001,
      PH_LENGTH  = 7'b0000010,
      PH_CONTENT = 7'b0000100,
      PH_TARGET  = 7'b0001000,
      PH_NAMEB   = 7'b0010000,
      PH_DONE    = 7'b0100000,
      PH_ERROR   = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  byte_class;
      logic [7:0]  byte_value;
      logic [1:0]  node_kind;
      logic        is_executable;
      logic [63:0] field_length;
      logic        last_of_field;
      logic [6:0]  nest_depth;
      logic [1:0]  parse_status;
   } rsp_type;

   typedef struct packed {
      phase_type            phase;
      logic [3:0]           tok;
      logic [3:0]           pos;
      logic [1:0]           lkind;
      logic [63:0]          acc;
      logic [63:0]          rem;
      logic [DEPTH_W-1:0]   depth;
      logic                 exe;
      logic [1:0]           dots;
      logic [1:0]           status;
      logic [63:0]          dlen;
      logic [1:0]           kind;
   } state_type;

   function automatic state_type asv_restart();
      state_type s;
      s.phase  = PH_TOKEN;
      s.tok    = TK_MAGIC;
      s.pos    = '0;
      s.lkind  = LK_CONT;
      s.acc    = '0;
      s.rem    = '0;
      s.depth  = '0;
      s.exe    = 1'b0;
      s.dots   = '0;
      s.status = ST_RUNNING;
      s.dlen   = '0;
      s.kind   = KIND_NONE;
      return s;
   endfunction

   function automatic logic [3:0] tok_len(input logic [3:0] t);
      logic [3:0] l;
      case (t)
         TK_MAGIC:     l = 4'd14;
         TK_REG:       l = 4'd13;
         TK_SYM:       l = 4'd13;
         TK_DIR:       l = 4'd15;
         TK_EXEC:      l = 4'd11;
         TK_CONT:      l = 4'd9;
         TK_CONT_ONLY: l = 4'd9;
         TK_TARG:      l = 4'd7;
         TK_NAME:      l = 4'd5;
         TK_ENTRY:     l = 4'd6;
         TK_END:       l = 4'd4;
         default:      l = 4'd0;
      endcase
      return l;
   endfunction

   function automatic logic [2:0] tok_group(input logic [3:0] t);
      logic [2:0] g;
      case (t)
         TK_MAGIC:                g = 3'd0;
         TK_REG, TK_SYM, TK_DIR:  g = 3'd1;
         TK_EXEC, TK_CONT:        g = 3'd2;
         TK_CONT_ONLY:            g = 3'd3;
         TK_TARG:                 g = 3'd4;
         TK_NAME:                 g = 3'd5;
         default:                 g = 3'd6;
      endcase
      return g;
   endfunction

   // Text right-justified: char pos sits at byte (len-1-pos) from the LSB.
   function automatic logic [127:0] tok_text(input logic [3:0] t);
      logic [127:0] x;
      case (t)
         TK_MAGIC:     x = "nix-archive-1\n";
         TK_REG:       x = "type:regular\n";
         TK_SYM:       x = "type:symlink\n";
         TK_DIR:       x = "type:directory\n";
         TK_EXEC:      x = "executable\n";
         TK_CONT:      x = "contents:";
         TK_CONT_ONLY: x = "contents:";
         TK_TARG:      x = "target:";
         TK_NAME:      x = "name:";
         TK_ENTRY:     x = "entry\n";
         TK_END:       x = "end\n";
         default:      x = '0;
      endcase
      return x;
   endfunction

   function automatic logic [7:0] tok_char(input logic [3:0] t, input logic [3:0] pos);
      logic [127:0] x;
      logic [3:0]   l;
      logic [3:0]   idx;
      x   = tok_text(t);
      l   = tok_len(t);
      idx = l - 4'd1 - pos;
      if (pos < l) return x[{idx, 3'b000} +: 8];
      return 8'd0;
   endfunction

   function automatic logic tok_prefix_eq(input logic [3:0] k, input logic [3:0] t,
                                          input logic [3:0] pos);
      logic eq;
      eq = 1'b1;
      for (int i = 0; i < 15; i++) begin
         if (4'(i) < pos && tok_char(k, 4'(i)) != tok_char(t, 4'(i))) eq = 1'b0;
      end
      return eq;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/archive_stream_validator.sv =====
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  req_data  (one stream byte per request)
// rsp       out        rsp_valid/rsp_ready  rsp_data  (one result per request)
// csr       in         csr_we               csr_index, csr_wdata
//
// One request per cycle unless a held result stalls req_ready; the result appears in the cycle after acceptance.
// The per-byte parse step is a single combinational pass into the result register.
// req_ready is high while the result register is empty or being drained.
// Synchronous reset clears the parse state and loads the register defaults.
`default_nettype none
`include "assert_macros.svh"
module archive_stream_validator (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire asv_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output asv_pkg::rsp_type      rsp_data,
   input  wire                   csr_we,
   input  wire                   csr_index,
   input  wire [15:0]            csr_wdata
);

   asv_pkg::state_type state_ff;
   asv_pkg::state_type state_in;
   asv_pkg::rsp_type   rsp_ff;
   asv_pkg::rsp_type   rsp_in;
   logic               rsp_valid_ff;
   logic [15:0]        max_target_ff;
   logic [7:0]         max_name_ff;
   logic               req_fire;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   asv_step u_step (
      .state_cur  (state_ff),
      .req        (req_data),
      .max_target (max_target_ff),
      .max_name   (max_name_ff),
      .state_nxt  (state_in),
      .rsp        (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= asv_pkg::asv_restart();
         rsp_valid_ff  <= 1'b0;
         max_target_ff <= 16'd4095;
         max_name_ff   <= 8'd255;
      end else begin
         if (req_fire) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            if (csr_index == asv_pkg::CSR_MAX_TARGET) max_target_ff <= csr_wdata;
            else max_name_ff <= csr_wdata[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) rsp_ff <= rsp_in;
   end

   `ASV_ASSERT(a_done_phase, (state_ff.status == asv_pkg::ST_DONE) |-> (state_ff.phase == asv_pkg::PH_DONE), "complete status outside done phase")
   `ASV_ASSERT(a_depth_max, state_ff.depth <= asv_pkg::DEPTH_W'(asv_pkg::MAX_DEPTH), "nesting depth beyond limit")
   `ASV_ASSERT_NEXT(a_rsp_follows, req_fire, rsp_valid_ff, "accepted request left no result")

endmodule
`default_nettype wire

// ===== rtl/core/asv_step.sv =====
`default_nettype none
module asv_step (
   input  wire asv_pkg::state_type state_cur,
   input  wire asv_pkg::req_type   req,
   input  wire logic [15:0]        max_target,
   input  wire logic [7:0]         max_name,
   output asv_pkg::state_type      state_nxt,
   output asv_pkg::rsp_type        rsp
);

   asv_pkg::state_type c;
   asv_pkg::state_type n;
   logic [7:0]  b;
   logic [2:0]  cls;
   logic        last;
   logic [3:0]  tn;
   logic        hit;
   logic        err;
   logic [3:0]  pos1;
   logic [63:0] acc1;
   logic [63:0] rem1;
   logic [1:0]  dots1;

   always_comb begin
      c     = req.first_byte ? asv_pkg::asv_restart() : state_cur;
      n     = c;
      b     = req.data_byte;
      cls   = asv_pkg::CLS_IGNORED;
      last  = 1'b0;
      tn    = c.tok;
      hit   = 1'b0;
      err   = 1'b0;
      pos1  = c.pos + 4'd1;
      acc1  = {((c.pos == 4'd0) ? 56'd0 : c.acc[55:0]), b};
      rem1  = c.rem - 64'd1;
      dots1 = (b == 8'h2E) ? ((c.dots < 2'd3) ? c.dots + 2'd1 : 2'd3) : 2'd3;

      unique case (c.phase)
         asv_pkg::PH_TOKEN: begin
            cls = asv_pkg::CLS_TOKEN;
            if (c.pos >= asv_pkg::tok_len(c.tok)) begin
               err = 1'b1;
            end else if (asv_pkg::tok_char(c.tok, c.pos) == b) begin
               hit = 1'b1;
            end else begin
               for (int k = asv_pkg::TK_COUNT - 1; k >= 0; k--) begin
                  if (4'(k) != c.tok
                      && asv_pkg::tok_group(4'(k)) == asv_pkg::tok_group(c.tok)
                      && c.pos < asv_pkg::tok_len(4'(k))
                      && asv_pkg::tok_prefix_eq(4'(k), c.tok, c.pos)
                      && asv_pkg::tok_char(4'(k), c.pos) == b) begin
                     hit = 1'b1;
                     tn  = 4'(k);
                  end
               end
               if (!hit) err = 1'b1;
            end
            if (hit) begin
               n.tok = tn;
               n.pos = pos1;
               if (pos1 == asv_pkg::tok_len(tn)) begin
                  n.pos = '0;
                  case (tn)
                     asv_pkg::TK_MAGIC: begin
                        n.tok  = asv_pkg::TK_REG;
                        n.kind = asv_pkg::KIND_NONE;
                     end
                     asv_pkg::TK_REG: begin
                        n.kind = asv_pkg::KIND_REG;
                        n.exe  = 1'b0;
                        n.tok  = asv_pkg::TK_EXEC;
                     end
                     asv_pkg::TK_SYM: begin
                        n.kind = asv_pkg::KIND_SYM;
                        n.exe  = 1'b0;
                        n.tok  = asv_pkg::TK_TARG;
                     end
                     asv_pkg::TK_DIR: begin
                        n.kind = asv_pkg::KIND_DIR;
                        n.exe  = 1'b0;
                        if (c.depth >= asv_pkg::DEPTH_W'(asv_pkg::MAX_DEPTH)) begin
                           err = 1'b1;
                        end else begin
                           n.depth = c.depth + 1'b1;
                           n.tok   = asv_pkg::TK_ENTRY;
                        end
                     end
                     asv_pkg::TK_EXEC: begin
                        n.exe = 1'b1;
                        n.tok = asv_pkg::TK_CONT_ONLY;
                     end
                     asv_pkg::TK_CONT, asv_pkg::TK_CONT_ONLY: begin
                        n.phase = asv_pkg::PH_LENGTH;
                        n.lkind = asv_pkg::LK_CONT;
                     end
                     asv_pkg::TK_TARG: begin
                        n.phase = asv_pkg::PH_LENGTH;
                        n.lkind = asv_pkg::LK_TARG;
                     end
                     asv_pkg::TK_NAME: begin
                        n.phase = asv_pkg::PH_LENGTH;
                        n.lkind = asv_pkg::LK_NAME;
                     end
                     asv_pkg::TK_ENTRY: begin
                        n.tok = asv_pkg::TK_NAME;
                     end
                     default: begin
                        // end of directory: close it, then the node is over
                        n.depth = (c.depth != '0) ? c.depth - 1'b1 : c.depth;
                        if (n.depth == '0) begin
                           n.phase  = asv_pkg::PH_DONE;
                           n.status = asv_pkg::ST_DONE;
                        end else begin
                           n.tok  = asv_pkg::TK_ENTRY;
                           n.kind = asv_pkg::KIND_DIR;
                        end
                     end
                  endcase
               end
            end
         end
         asv_pkg::PH_LENGTH: begin
            cls   = asv_pkg::CLS_LENGTH;
            n.acc = acc1;
            n.pos = pos1;
            if (pos1 == 4'd8) begin
               n.pos  = '0;
               n.dlen = acc1;
               n.rem  = acc1;
               case (c.lkind)
                  asv_pkg::LK_CONT: begin
                     if (acc1 == 64'd0) begin
                        if (c.depth == '0) begin
                           n.phase  = asv_pkg::PH_DONE;
                           n.status = asv_pkg::ST_DONE;
                        end else begin
                           n.phase = asv_pkg::PH_TOKEN;
                           n.tok   = asv_pkg::TK_ENTRY;
                           n.kind  = asv_pkg::KIND_DIR;
                        end
                     end else begin
                        n.phase = asv_pkg::PH_CONTENT;
                     end
                  end
                  asv_pkg::LK_TARG: begin
                     if (acc1 == 64'd0 || acc1 > {48'd0, max_target}) err = 1'b1;
                     else n.phase = asv_pkg::PH_TARGET;
                  end
                  default: begin
                     if (acc1 == 64'd0 || acc1 > {56'd0, max_name}) begin
                        err = 1'b1;
                     end else begin
                        n.phase = asv_pkg::PH_NAMEB;
                        n.dots  = '0;
                     end
                  end
               endcase
            end
         end
         asv_pkg::PH_CONTENT, asv_pkg::PH_TARGET: begin
            cls   = (c.phase == asv_pkg::PH_CONTENT) ? asv_pkg::CLS_CONTENT
                                                     : asv_pkg::CLS_TARGET;
            n.rem = rem1;
            if (rem1 == 64'd0) begin
               last = 1'b1;
               if (c.depth == '0) begin
                  n.phase  = asv_pkg::PH_DONE;
                  n.status = asv_pkg::ST_DONE;
               end else begin
                  n.phase = asv_pkg::PH_TOKEN;
                  n.tok   = asv_pkg::TK_ENTRY;
                  n.pos   = '0;
                  n.kind  = asv_pkg::KIND_DIR;
               end
            end
         end
         asv_pkg::PH_NAMEB: begin
            cls    = asv_pkg::CLS_NAME;
            n.rem  = rem1;
            n.dots = dots1;
            last   = (rem1 == 64'd0);
            if (b == 8'h2F || b == 8'h00) begin
               err = 1'b1;
            end else if (last) begin
               if (dots1 == 2'd1 || dots1 == 2'd2) begin
                  err = 1'b1;
               end else begin
                  n.phase = asv_pkg::PH_TOKEN;
                  n.tok   = asv_pkg::TK_REG;
                  n.pos   = '0;
                  n.kind  = asv_pkg::KIND_NONE;
               end
            end
         end
         default: begin
            cls = asv_pkg::CLS_IGNORED;
         end
      endcase

      if (err) begin
         n.phase  = asv_pkg::PH_ERROR;
         n.status = asv_pkg::ST_ERROR;
      end

      state_nxt         = n;
      rsp.byte_class    = cls;
      rsp.byte_value    = b;
      rsp.node_kind     = n.kind;
      rsp.is_executable = n.exe;
      rsp.field_length  = n.dlen;
      rsp.last_of_field = last;
      rsp.nest_depth    = 7'(n.depth);
      rsp.parse_status  = n.status;
   end

endmodule
`default_nettype wire
